FILE: src/c3if_pkg.sv
// ----------------------------------------------------------------------------
// c3if_pkg
// Shared types and constants of the 3x3 convolution image filter.
// ----------------------------------------------------------------------------
`default_nettype none

package c3if_pkg;

  localparam int PIX_W   = 8;   // pixel and kernel weight width
  localparam int COEF_W  = 24;  // one kernel row, three weights
  localparam int DIV_W   = 8;
  localparam int DIM_W   = 11;  // image_width / image_height registers
  localparam int POS_W   = 10;  // out_row / out_col
  localparam int PROD_W  = 17;  // unsigned pixel times signed weight
  localparam int SUM_W   = 20;  // signed sum of nine products
  localparam int REM_W   = 19;  // positive part of the sum
  localparam int QUO_W   = 8;
  localparam int STEP_W  = 3;
  localparam int TAP_W   = 2;
  localparam int MIN_DIM = 3;
  localparam int ROW_LIMIT = 1024;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  // register index, taken from paddr[4:2]
  localparam logic [2:0] REG_COEF_TOP = 3'd0;
  localparam logic [2:0] REG_COEF_MID = 3'd1;
  localparam logic [2:0] REG_COEF_BOT = 3'd2;
  localparam logic [2:0] REG_DIVISOR  = 3'd3;
  localparam logic [2:0] REG_WIDTH    = 3'd4;
  localparam logic [2:0] REG_HEIGHT   = 3'd5;

  localparam logic [COEF_W-1:0] COEF_TOP_RST = 24'd0;
  localparam logic [COEF_W-1:0] COEF_MID_RST = 24'd256;
  localparam logic [COEF_W-1:0] COEF_BOT_RST = 24'd0;
  localparam logic [DIV_W-1:0]  DIVISOR_RST  = 8'd1;
  localparam logic [DIM_W-1:0]  DIM_RST      = 11'd1024;

  localparam logic [TAP_W-1:0] TAP_LAST = 2'd2;
  localparam logic [QUO_W-1:0] QUO_MAX  = 8'd255;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MAC,
    S_PREP,
    S_DIV,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

FILE: src/c3if_ram.sv
// ----------------------------------------------------------------------------
// c3if_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module c3if_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DATA_W-1:0]        wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: src/conv3x3_image_filter.sv
// ----------------------------------------------------------------------------
// conv3x3_image_filter
// 3x3 convolution over a raster pixel stream with two line stores.
// ----------------------------------------------------------------------------
// Pixels of one colour plane enter in raster order, one word each. Each pixel
// is handled on its own: the accept cycle reads both line stores at the
// column, the next cycle shifts the 3x3 window and writes the line stores
// back, and a border pixel ends there. An interior pixel then runs a
// multiply-accumulate over the nine kernel taps through one 8x8 multiplier
// and an 8-step restoring divider before the result enters the output
// register; when the sum is not positive or the quotient saturates the
// divider is skipped. The input is ready again once that register has
// taken the result, so a stalled result only holds the block when the next
// one is due.
// Results carry the centre row and column; tlast marks the last interior
// result of the frame. Reads and writes of the same line store entry never
// overlap since one item finishes its write-back before the next read.
`default_nettype none

module conv3x3_image_filter
  import c3if_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // apb configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  // pixel input
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,   // [7:0] pixel
  // filtered output
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [31:0]           m_axis_tdata,   // [7:0] filtered_pixel,
                                                     // [17:8] out_row,
                                                     // [27:18] out_col
  output logic                       m_axis_tlast    // frame_last
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = $clog2(MAX_WIDTH + 1);
  localparam int XW = (EW > DIM_W) ? EW : DIM_W;

  // configuration registers
  logic [COEF_W-1:0] coef_top_row;
  logic [COEF_W-1:0] coef_mid_row;
  logic [COEF_W-1:0] coef_bot_row;
  logic [DIV_W-1:0]  divisor;
  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic              cfg_wr;

  state_t state, state_next;

  logic [POS_W-1:0] row_count;
  logic [CW-1:0]    col_count;

  // word being processed
  logic [PIX_W-1:0] cur_px;
  logic [CW-1:0]    cur_col;
  logic [POS_W-1:0] cur_row_out;
  logic [POS_W-1:0] cur_col_out;
  logic             cur_interior;
  logic             cur_last;

  logic [PIX_W-1:0] win [0:2][0:2];
  logic [TAP_W-1:0] tap_row;
  logic [TAP_W-1:0] tap_col;
  logic signed [SUM_W-1:0] acc;
  logic [REM_W-1:0]  rem;
  logic [QUO_W-1:0]  quo;
  logic [STEP_W-1:0] step;

  logic [PIX_W-1:0] up1, up2;
  logic             in_acc;
  logic             ram_we;
  logic             out_load;

  // ---------------------------------------------------------------- apb
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_top_row <= COEF_TOP_RST;
      coef_mid_row <= COEF_MID_RST;
      coef_bot_row <= COEF_BOT_RST;
      divisor      <= DIVISOR_RST;
      image_width  <= DIM_RST;
      image_height <= DIM_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_COEF_TOP: coef_top_row <= pwdata[COEF_W-1:0];
        REG_COEF_MID: coef_mid_row <= pwdata[COEF_W-1:0];
        REG_COEF_BOT: coef_bot_row <= pwdata[COEF_W-1:0];
        REG_DIVISOR:  divisor      <= pwdata[DIV_W-1:0];
        REG_WIDTH:    image_width  <= pwdata[DIM_W-1:0];
        REG_HEIGHT:   image_height <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_COEF_TOP: prdata = APB_DATA_W'(coef_top_row);
      REG_COEF_MID: prdata = APB_DATA_W'(coef_mid_row);
      REG_COEF_BOT: prdata = APB_DATA_W'(coef_bot_row);
      REG_DIVISOR:  prdata = APB_DATA_W'(divisor);
      REG_WIDTH:    prdata = APB_DATA_W'(image_width);
      REG_HEIGHT:   prdata = APB_DATA_W'(image_height);
      default:      prdata = '0;
    endcase
  end

  // ------------------------------------------------------ frame geometry
  logic [XW-1:0]    width_x, width_eff, col_x;
  logic [DIM_W-1:0] height_eff, row_x;
  logic             interior, frame_end, col_wrap, row_wrap;

  always_comb begin
    width_x = XW'(image_width);
    if (width_x < XW'(MIN_DIM)) begin
      width_eff = XW'(MIN_DIM);
    end else if (width_x > XW'(MAX_WIDTH)) begin
      width_eff = XW'(MAX_WIDTH);
    end else begin
      width_eff = width_x;
    end
    if (image_height < DIM_W'(MIN_DIM)) begin
      height_eff = DIM_W'(MIN_DIM);
    end else if (image_height > DIM_W'(ROW_LIMIT)) begin
      height_eff = DIM_W'(ROW_LIMIT);
    end else begin
      height_eff = image_height;
    end
    col_x     = XW'(col_count);
    row_x     = DIM_W'(row_count);
    interior  = (row_x >= DIM_W'(2)) && (col_x >= XW'(2)) &&
                (row_x < height_eff) && (col_x < width_eff);
    frame_end = (row_x == height_eff - DIM_W'(1)) && (col_x == width_eff - XW'(1));
    col_wrap  = (col_x + XW'(1)) >= width_eff;
    row_wrap  = (row_x + DIM_W'(1)) >= height_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (in_acc) begin
      if (col_wrap) begin
        col_count <= '0;
        row_count <= row_wrap ? '0 : row_count + POS_W'(1);
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_px      <= s_axis_tdata[PIX_W-1:0];
      cur_col     <= col_count;
      cur_row_out <= row_count - POS_W'(1);
      cur_col_out <= POS_W'(col_count - CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_interior <= 1'b0;
      cur_last     <= 1'b0;
    end else if (in_acc) begin
      cur_interior <= interior;
      cur_last     <= frame_end;
    end
  end

  // ---------------------------------------------------------- line stores
  // store a holds the previous row, store b the row before it
  c3if_ram #(.DATA_W(PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_col),
    .wdata (cur_px),
    .re    (in_acc),
    .raddr (col_count),
    .rdata (up1)
  );

  c3if_ram #(.DATA_W(PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_col),
    .wdata (up1),
    .re    (in_acc),
    .raddr (col_count),
    .rdata (up2)
  );

  // window shifts left, new right column is line b, line a, pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (ram_we) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= up2;
      win[1][2] <= up1;
      win[2][2] <= cur_px;
    end
  end

  // ------------------------------------------------------- multiply-add
  logic [COEF_W-1:0]       coef_sel;
  logic [PIX_W-1:0]        win_pix;
  logic signed [PIX_W-1:0] wt;
  logic signed [PROD_W-1:0] prod;

  always_comb begin
    case (tap_row)
      2'd0:    coef_sel = coef_top_row;
      2'd1:    coef_sel = coef_mid_row;
      default: coef_sel = coef_bot_row;
    endcase
    wt      = $signed(coef_sel[{tap_col, 3'b000} +: PIX_W]);
    win_pix = win[tap_row][tap_col];
    prod    = $signed({1'b0, win_pix}) * wt;
  end

  // ------------------------------------------------------------ divider
  logic [DIV_W-1:0] dvs;
  logic [REM_W-1:0] dvs_full, dvs_step;

  always_comb begin
    dvs      = (divisor == '0) ? DIV_W'(1) : divisor;
    dvs_full = {3'b000, dvs, 8'h00};
    dvs_step = REM_W'(dvs) << step;
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_LOAD: begin
        tap_row <= '0;
        tap_col <= '0;
        acc     <= '0;
      end
      S_MAC: begin
        acc <= acc + SUM_W'(prod);
        if (tap_col == TAP_LAST) begin
          tap_col <= '0;
          tap_row <= tap_row + TAP_W'(1);
        end else begin
          tap_col <= tap_col + TAP_W'(1);
        end
      end
      S_PREP: begin
        rem  <= acc[REM_W-1:0];
        step <= STEP_W'(QUO_W - 1);
        // a non-positive sum gives zero, a large one saturates
        if (acc[SUM_W-1] || (acc == '0)) begin
          quo <= '0;
        end else if (acc[REM_W-1:0] >= dvs_full) begin
          quo <= QUO_MAX;
        end else begin
          quo <= '0;
        end
      end
      S_DIV: begin
        if (rem >= dvs_step) begin
          rem       <= rem - dvs_step;
          quo[step] <= 1'b1;
        end
        step <= step - STEP_W'(1);
      end
      default: ;
    endcase
  end

  logic prep_done;
  assign prep_done = acc[SUM_W-1] || (acc == '0) || (acc[REM_W-1:0] >= dvs_full);

  // -------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        ram_we     = 1'b1;
        state_next = cur_interior ? S_MAC : S_IDLE;
      end
      S_MAC: begin
        if ((tap_row == TAP_LAST) && (tap_col == TAP_LAST)) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        state_next = prep_done ? S_OUT : S_DIV;
      end
      S_DIV: begin
        if (step == '0) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_acc = s_axis_tvalid & s_axis_tready;

  // ------------------------------------------------------ output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {4'h0, cur_col_out, cur_row_out, quo};
      m_axis_tlast <= cur_last;
    end
  end

  // ----------------------------------------------------------- assertions
  a_load_after_accept: assert property (@(posedge clk) disable iff (rst)
    state == S_LOAD |-> $past(s_axis_tvalid && s_axis_tready))
    else $error("window load without an accepted pixel");

  a_mac_starts_clean: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAC && $past(state) != S_MAC) |-> (acc == '0 && tap_row == '0 &&
      tap_col == '0))
    else $error("accumulator not cleared at start of kernel pass");

  a_prep_after_nine: assert property (@(posedge clk) disable iff (rst)
    state == S_PREP |-> $past(state == S_MAC && tap_row == TAP_LAST &&
      tap_col == TAP_LAST))
    else $error("divide started before all nine taps");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && m_axis_tvalid && !m_axis_tready) |=> state == S_OUT)
    else $error("result dropped while output stalled");

endmodule

`default_nettype wire
